// ===== design/m3inv_pkg.sv =====
// Shared constants, widths and cofactor tables for the 3x3 matrix inverse pipeline.
// No dependencies; the inverse unit imports this package.
package m3inv_pkg;

	// Port width of every matrix and inverse entry
	localparam int PORT_W = 32;
	// Used entry width and fraction bits of the fixed-point format
	localparam int EW = 32;
	localparam int FB = 16;

	// Pair product, cofactor, determinant widths
	localparam int PW = 2 * EW;
	localparam int CW = 2 * EW + 1;
	localparam int DW = 3 * EW + 2;
	// Dividend: cofactor magnitude scaled by 2^(2*FB)
	localparam int SHIFT = 2 * FB;
	localparam int NW = CW + SHIFT;
	// Dividend bits above the quotient window
	localparam int HW = NW - EW;
	// Compare width for the overflow check
	localparam int XW = ((HW > DW) ? HW : DW) + 1;

	localparam int NCOF = 9;

	// Cofactor k = m[A]*m[B] - m[C]*m[D], entries in row-major order
	localparam int CF_A [0:NCOF-1] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int CF_B [0:NCOF-1] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int CF_C [0:NCOF-1] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int CF_D [0:NCOF-1] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	// Cofactors that pair with row 0 in the determinant expansion
	localparam int DET_COF [0:2] = '{0, 3, 6};

	localparam logic [EW-1:0] LIM_POS = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] LIM_NEG = {1'b1, {(EW-1){1'b0}}};

endpackage

// ===== design/matrix3x3_inverse_unit.sv =====
// Pipelined 3x3 fixed-point matrix inverse by the adjugate method.
// Depends on m3inv_pkg for widths and cofactor tables.
//
// Usage:
// - Input channel: in_valid / in_stall with nine signed Q16.16 entries
//   in_r0c0 .. in_r2c2. A transaction is taken when in_valid is high and
//   in_stall is low.
// - Output channel: out_valid / out_stall with the nine inverse entries
//   inv_r0c0 .. inv_r2c2, a singular flag (determinant zero, entries zero)
//   and a saturated flag (an entry was clipped to the Q16.16 range).
// - The pipeline has six stages for products, cofactors and the
//   determinant, one divider setup stage, one restoring divider stage per
//   quotient bit (32), and the output register.
// - Throughput is one matrix per cycle when not stalled; nine bit-per-stage
//   dividers run side by side, so no item waits on another.
// - When out_stall holds a valid result, the whole pipeline freezes and
//   in_stall rises; bubbles keep moving while the output register is empty.
// - Reset clears all valid bits; the block is ready on the first cycle.
module matrix3x3_inverse_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r0c0,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r0c1,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r0c2,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r1c0,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r1c1,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r1c2,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r2c0,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r2c1,
	input  logic signed [m3inv_pkg::PORT_W-1:0] in_r2c2,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r0c0,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r0c1,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r0c2,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r1c0,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r1c1,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r1c2,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r2c0,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r2c1,
	output logic signed [m3inv_pkg::PORT_W-1:0] inv_r2c2,
	output logic                                singular,
	output logic                                saturated
);
	import m3inv_pkg::*;

	logic adv;
	logic signed [EW-1:0] m_in [0:8];

	// Stage registers
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [PW-1:0] pa_s1 [0:NCOF-1];
	logic signed [PW-1:0] pb_s1 [0:NCOF-1];
	logic signed [EW-1:0] r0_s1 [0:2];
	logic signed [CW-1:0] cof_s2 [0:NCOF-1];
	logic signed [EW-1:0] r0_s2 [0:2];
	logic signed [2*EW:0] pl_s3 [0:2];
	logic signed [2*EW:0] ph_s3 [0:2];
	logic [CW-1:0]        cmag_s3 [0:NCOF-1];
	logic                 cneg_s3 [0:NCOF-1];
	logic signed [DW-1:0] term_s4 [0:2];
	logic [CW-1:0]        cmag_s4 [0:NCOF-1];
	logic                 cneg_s4 [0:NCOF-1];
	logic signed [DW-1:0] det_s5;
	logic [CW-1:0]        cmag_s5 [0:NCOF-1];
	logic                 cneg_s5 [0:NCOF-1];
	logic [DW-1:0]        dmag_s6;
	logic                 dneg_s6, dzero_s6;
	logic [CW-1:0]        cmag_s6 [0:NCOF-1];
	logic                 cneg_s6 [0:NCOF-1];

	// Divider stages: index 0 is the setup stage, index j+1 follows quotient bit j
	logic          dv_v_s    [0:EW];
	logic [DW-1:0] dv_dmag_s [0:EW];
	logic          dv_zero_s [0:EW];
	logic [DW-1:0] dv_rem_s  [0:EW][0:NCOF-1];
	logic [EW-1:0] dv_q_s    [0:EW][0:NCOF-1];
	logic [EW-1:0] dv_low_s  [0:EW][0:NCOF-1];
	logic          dv_ovf_s  [0:EW][0:NCOF-1];
	logic          dv_qneg_s [0:EW][0:NCOF-1];

	// Output register
	logic                 out_v_q;
	logic signed [PORT_W-1:0] inv_q [0:NCOF-1];
	logic                 sing_q, sat_q;

	// Advance whenever the output register is free or being drained
	assign adv      = !out_v_q || !out_stall;
	assign in_stall = !adv;

	assign m_in[0] = in_r0c0[EW-1:0];
	assign m_in[1] = in_r0c1[EW-1:0];
	assign m_in[2] = in_r0c2[EW-1:0];
	assign m_in[3] = in_r1c0[EW-1:0];
	assign m_in[4] = in_r1c1[EW-1:0];
	assign m_in[5] = in_r1c2[EW-1:0];
	assign m_in[6] = in_r2c0[EW-1:0];
	assign m_in[7] = in_r2c1[EW-1:0];
	assign m_in[8] = in_r2c2[EW-1:0];

	// Advance the valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	generate
		for (genvar k = 0; k < NCOF; k++) begin : g_cof
			// Stage 1 and 2: pair products, then their difference
			always_ff @(posedge clk) begin
				if (adv) begin
					pa_s1[k]  <= m_in[CF_A[k]] * m_in[CF_B[k]];
					pb_s1[k]  <= m_in[CF_C[k]] * m_in[CF_D[k]];
					cof_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
				end
			end

			// Stage 3 to 6: carry sign and magnitude of each cofactor
			always_ff @(posedge clk) begin
				if (adv) begin
					cneg_s3[k] <= cof_s2[k][CW-1];
					cmag_s3[k] <= cof_s2[k][CW-1] ? CW'(-cof_s2[k]) : CW'(cof_s2[k]);
					cneg_s4[k] <= cneg_s3[k];
					cmag_s4[k] <= cmag_s3[k];
					cneg_s5[k] <= cneg_s4[k];
					cmag_s5[k] <= cmag_s4[k];
					cneg_s6[k] <= cneg_s5[k];
					cmag_s6[k] <= cmag_s5[k];
				end
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_det
			logic signed [EW:0] cof_hi, cof_lo;

			// Split the cofactor so each multiply stays near 32 by 32
			assign cof_hi = cof_s2[DET_COF[i]][CW-1:EW];
			assign cof_lo = {1'b0, cof_s2[DET_COF[i]][EW-1:0]};

			always_ff @(posedge clk) begin
				if (adv) begin
					r0_s1[i]   <= m_in[i];
					r0_s2[i]   <= r0_s1[i];
					pl_s3[i]   <= r0_s2[i] * cof_lo;
					ph_s3[i]   <= r0_s2[i] * cof_hi;
					term_s4[i] <= (DW'(ph_s3[i]) <<< EW) + DW'(pl_s3[i]);
				end
			end
		end
	endgenerate

	// Sum the expansion, then take sign and magnitude of the determinant
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5   <= term_s4[0] + term_s4[1] + term_s4[2];
			dneg_s6  <= det_s5[DW-1];
			dzero_s6 <= (det_s5 == '0);
			dmag_s6  <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
		end
	end

	// Divider valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= EW; j++) begin
				dv_v_s[j] <= 1'b0;
			end
		end else if (adv) begin
			dv_v_s[0] <= v_s6;
			for (int j = 0; j < EW; j++) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end
	end

	// Setup stage: overflow check and initial remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_dmag_s[0] <= dmag_s6;
			dv_zero_s[0] <= dzero_s6;
		end
	end

	generate
		for (genvar k = 0; k < NCOF; k++) begin : g_setup
			logic [NW-1:0] num;
			logic [HW-1:0] num_hi;

			assign num    = NW'(cmag_s6[k]) << SHIFT;
			assign num_hi = num[NW-1:EW];

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_ovf_s[0][k]  <= XW'(num_hi) >= XW'(dmag_s6);
					dv_rem_s[0][k]  <= DW'(num_hi);
					dv_low_s[0][k]  <= num[EW-1:0];
					dv_q_s[0][k]    <= '0;
					dv_qneg_s[0][k] <= cneg_s6[k] ^ dneg_s6;
				end
			end
		end

		// One restoring step per stage: shift in a dividend bit, subtract if it fits
		for (genvar j = 0; j < EW; j++) begin : g_div
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_dmag_s[j+1] <= dv_dmag_s[j];
					dv_zero_s[j+1] <= dv_zero_s[j];
				end
			end

			for (genvar k = 0; k < NCOF; k++) begin : g_lane
				logic [DW:0] trial, diff;
				logic        fits;

				assign trial = {dv_rem_s[j][k], dv_low_s[j][k][EW-1]};
				assign diff  = trial - {1'b0, dv_dmag_s[j]};
				assign fits  = trial >= {1'b0, dv_dmag_s[j]};

				always_ff @(posedge clk) begin
					if (adv) begin
						dv_rem_s[j+1][k]  <= fits ? diff[DW-1:0] : trial[DW-1:0];
						dv_q_s[j+1][k]    <= {dv_q_s[j][k][EW-2:0], fits};
						dv_low_s[j+1][k]  <= dv_low_s[j][k] << 1;
						dv_ovf_s[j+1][k]  <= dv_ovf_s[j][k];
						dv_qneg_s[j+1][k] <= dv_qneg_s[j][k];
					end
				end
			end
		end
	endgenerate

	// Saturate, apply sign, and hold the result for the receiver
	logic signed [PORT_W-1:0] inv_d [0:NCOF-1];
	logic                     sat_d;

	always_comb begin
		logic [EW-1:0] lim, qm, val;
		logic          clip;
		sat_d = 1'b0;
		for (int k = 0; k < NCOF; k++) begin
			lim  = dv_qneg_s[EW][k] ? LIM_NEG : LIM_POS;
			clip = dv_ovf_s[EW][k] || (dv_q_s[EW][k] > lim);
			qm   = clip ? lim : dv_q_s[EW][k];
			val  = dv_qneg_s[EW][k] ? EW'(-qm) : qm;
			inv_d[k] = dv_zero_s[EW] ? '0 : PORT_W'(signed'(val));
			sat_d = sat_d | (clip && !dv_zero_s[EW]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v_s[EW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NCOF; k++) begin
				inv_q[k] <= inv_d[k];
			end
			sing_q <= dv_zero_s[EW];
			sat_q  <= sat_d;
		end
	end

	assign out_valid = out_v_q;
	assign inv_r0c0  = inv_q[0];
	assign inv_r0c1  = inv_q[1];
	assign inv_r0c2  = inv_q[2];
	assign inv_r1c0  = inv_q[3];
	assign inv_r1c1  = inv_q[4];
	assign inv_r1c2  = inv_q[5];
	assign inv_r2c0  = inv_q[6];
	assign inv_r2c1  = inv_q[7];
	assign inv_r2c2  = inv_q[8];
	assign singular  = sing_q;
	assign saturated = sat_q;

endmodule

// ===== tb/tb_matrix3x3_inverse_unit.sv =====
// Self-checking testbench for the pipelined 3x3 Q16.16 matrix inverse unit.
// Depends on m3inv_pkg and matrix3x3_inverse_unit; predicts each inverse exactly.
module tb_matrix3x3_inverse_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import m3inv_pkg::*;

	localparam int N_RANDOM    = 1620;
	localparam int QUIET_TAIL  = 200;
	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 60;
	localparam logic [PORT_W-1:0] ONE = 32'h0001_0000;

	typedef logic [8:0][PORT_W-1:0] matrix_t;
	typedef struct packed {
		matrix_t e;
		logic    singular;
		logic    saturated;
	} inverse_t;
	typedef logic signed [191:0] wide_t;

	// Exact predictor plus the queue of inverses still owed by the block
	class inverse_scoreboard;
		inverse_t pending[$];
		int       errors;

		function inverse_t invert(matrix_t m);
			wide_t    a[9];
			wide_t    cof[9];
			wide_t    det, dmag, cmag, q, lim;
			logic     qneg;
			inverse_t r;
			for (int k = 0; k < 9; k++) a[k] = $signed(m[k]);
			det = a[0] * a[4] * a[8] + a[1] * a[5] * a[6] + a[2] * a[3] * a[7]
				- a[6] * a[4] * a[2] - a[7] * a[5] * a[0] - a[8] * a[3] * a[1];
			r = '0;
			if (det == 0) begin
				r.singular = 1'b1;
				return r;
			end
			// Transposed adjugate, row-major
			cof[0] =   a[4] * a[8] - a[7] * a[5];
			cof[1] = -(a[1] * a[8] - a[7] * a[2]);
			cof[2] =   a[1] * a[5] - a[4] * a[2];
			cof[3] = -(a[3] * a[8] - a[6] * a[5]);
			cof[4] =   a[0] * a[8] - a[6] * a[2];
			cof[5] = -(a[0] * a[5] - a[3] * a[2]);
			cof[6] =   a[3] * a[7] - a[6] * a[4];
			cof[7] = -(a[0] * a[7] - a[6] * a[1]);
			cof[8] =   a[0] * a[4] - a[3] * a[1];
			dmag = (det < 0) ? -det : det;
			for (int k = 0; k < 9; k++) begin
				qneg = (cof[k] < 0) != (det < 0);
				cmag = (cof[k] < 0) ? -cof[k] : cof[k];
				q = (cmag <<< (2 * FB)) / dmag;
				lim = qneg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
				if (q > lim) begin
					q = lim;
					r.saturated = 1'b1;
				end
				if (qneg) q = -q;
				r.e[k] = q[PORT_W-1:0];
			end
			return r;
		endfunction

		function void note_matrix(matrix_t m);
			pending.push_back(invert(m));
		endfunction

		function void check_inverse(inverse_t got);
			inverse_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, nothing pending", $realtime);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (got.e[k] !== want.e[k]) begin
					$display("%0t: entry %0d expected %h actual %h",
						$realtime, k, want.e[k], got.e[k]);
					errors++;
				end
			if (got.singular !== want.singular) begin
				$display("%0t: singular expected %b actual %b",
					$realtime, want.singular, got.singular);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$display("%0t: saturated expected %b actual %b",
					$realtime, want.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	matrix_t in_m = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [PORT_W-1:0] inv [9];
	logic singular, saturated;

	inverse_scoreboard sb = new();
	int  accepted = 0;
	bit  quiet = 0;
	bit  held_off = 0;
	int  cycles = 0;

	matrix3x3_inverse_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_r0c0(in_m[0]), .in_r0c1(in_m[1]), .in_r0c2(in_m[2]),
		.in_r1c0(in_m[3]), .in_r1c1(in_m[4]), .in_r1c2(in_m[5]),
		.in_r2c0(in_m[6]), .in_r2c1(in_m[7]), .in_r2c2(in_m[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
		.inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
		.inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
		.singular(singular), .saturated(saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		inverse_t got;
		if (arst_n && out_valid && !out_stall) begin
			for (int k = 0; k < 9; k++) got.e[k] = inv[k];
			got.singular = singular;
			got.saturated = saturated;
			sb.check_inverse(got);
		end
	end

	// Receiver: random stall bursts, one long hold-off, none in the tail
	initial begin
		forever begin
			@(posedge clk);
			if (!held_off && accepted >= HOLD_AT) begin
				held_off = 1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one matrix and hold it until the transaction completes
	task automatic send_matrix(matrix_t m);
		if (!quiet && in_valid && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_m <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_matrix(m);
		accepted++;
	endtask

	function automatic logic [PORT_W-1:0] near_one();
		return PORT_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
	endfunction

	function automatic matrix_t diag(logic [PORT_W-1:0] d);
		matrix_t m = '0;
		m[0] = d;
		m[4] = d;
		m[8] = d;
		return m;
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t m;
		int mode = $urandom_range(0, 9);
		for (int k = 0; k < 9; k++) m[k] = (mode < 3) ? $urandom() : near_one();
		case (mode)
			// Duplicate a row to force a zero determinant
			6: for (int k = 0; k < 3; k++) m[6 + k] = m[k];
			// Nearly singular: tiny determinant drives saturation
			7: begin
				for (int k = 0; k < 3; k++) m[6 + k] = m[k];
				m[8] = m[8] + PORT_W'($urandom_range(1, 3));
			end
			// Small entries, sometimes a zero row
			8: begin
				for (int k = 0; k < 9; k++) m[k] = PORT_W'($urandom_range(0, 8)) - 4;
				if ($urandom_range(0, 3) == 0) m[5:3] = '0;
			end
			// Diagonal raised by 4.0 toward dominance and good conditioning
			9: for (int k = 0; k < 9; k += 4) m[k] = m[k] + (ONE << 2);
			default: ;
		endcase
		return m;
	endfunction

	initial begin
		matrix_t m;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners
		send_matrix(diag(ONE));
		send_matrix(diag(-ONE));
		send_matrix('0);
		send_matrix(diag(ONE << 1));
		send_matrix(diag(ONE >> 1));
		send_matrix(diag(32'h0000_0001));
		send_matrix(diag(32'hFFFF_FFFF));
		send_matrix(diag(32'h7FFF_FFFF));
		send_matrix(diag(32'h8000_0000));
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'h8000_0000}});
		send_matrix({9{ONE}});
		m = '0; m[1] = ONE; m[5] = ONE; m[6] = ONE;
		send_matrix(m);
		m = '0; m[2] = -ONE; m[4] = ONE << 3; m[6] = ONE;
		send_matrix(m);
		m = diag(ONE); m[1] = 32'h8000_0000; m[2] = 32'h7FFF_FFFF; m[5] = 32'h8000_0000;
		send_matrix(m);
		m = diag(32'h8000_0000); m[3] = 32'h7FFF_FFFF; m[7] = 32'h7FFF_FFFF;
		send_matrix(m);
		m = diag(32'h0000_0001); m[0] = 32'h7FFF_FFFF; m[1] = 32'h0000_0001;
		send_matrix(m);
		m = diag(ONE); m[8] = 32'hFFFF_FFFF;
		send_matrix(m);
		for (int k = 0; k < 9; k++) m[k] = $urandom();
		send_matrix(m);

		// Random body, idle-free tail
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - QUIET_TAIL) quiet = 1;
			send_matrix(random_matrix());
		end
		in_valid <= 1'b0;

		// Drain and settle
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/m3inv_pkg.sv
design/matrix3x3_inverse_unit.sv
tb/tb_matrix3x3_inverse_unit.sv
